@@ sv/assert_macros.svh @@
// assertion macros used by the top level rtl file of the block copy address generator
// no dependencies; take it in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is low
`define CHK_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/mbcag_pkg.sv @@
// shared constants, types and helper functions of the block copy address generator
// no dependencies; imported by every module of the block
package mbcag_pkg;

    // sizes
    localparam int MAX_DIMS       = 4;
    localparam int INDEX_BITS     = 16;
    localparam int ADDR_BITS      = 32;
    localparam int CFG_BITS       = 64;
    localparam int LAYOUT_BITS    = 22;
    localparam int LINK_LSB       = 6;
    localparam int DIM_FIELD_BITS = 3;
    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_BITS   = 3;
    localparam int OUT_ADDR_BITS  = 32;
    localparam int COUNT_BITS     = $clog2(MAX_DIMS + 1);
    localparam int STRIDE_STEPS   = (MAX_DIMS > 1) ? MAX_DIMS - 1 : 1;
    localparam int STEP_BITS      = (STRIDE_STEPS > 1) ? $clog2(STRIDE_STEPS) : 1;
    localparam int SIDE_SRC       = 0;
    localparam int SIDE_DST       = 1;

    // register reset values
    localparam logic [CFG_BITS-1:0]    CFG_RESET    = 64'h0001_0001_0001_0001;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_RESET = 22'd73;

    // configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SRC_EXTENTS = 3'd0,
        REG_SRC_STARTS  = 3'd1,
        REG_SRC_ENDS    = 3'd2,
        REG_DST_EXTENTS = 3'd3,
        REG_DST_STARTS  = 3'd4,
        REG_DST_ENDS    = 3'd5,
        REG_LAYOUT      = 3'd6
    } t_reg_idx;

    typedef logic [MAX_DIMS-1:0][INDEX_BITS-1:0] t_index_vec;
    typedef logic [MAX_DIMS-1:0][ADDR_BITS-1:0]  t_stride_vec;

    // control handed to every dimension cell
    typedef struct packed {
        logic load_init;
        logic step;
        logic restart;
        logic active;
    } t_cell_ctrl;

    // packed per-dimension field, zero where it does not fit the register
    function automatic logic [INDEX_BITS-1:0] field_of(input logic [CFG_BITS-1:0] reg_val,
                                                       input int d);
        logic [CFG_BITS-1:0] sh;
        sh = reg_val >> (d * INDEX_BITS);
        return (d * INDEX_BITS < CFG_BITS) ? sh[INDEX_BITS-1:0] : '0;
    endfunction

    function automatic logic [INDEX_BITS-1:0] umin(input logic [INDEX_BITS-1:0] a,
                                                   input logic [INDEX_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // dimension count of one side, limited to MAX_DIMS
    function automatic logic [COUNT_BITS-1:0] dim_count(input logic [LAYOUT_BITS-1:0] layout,
                                                        input int side);
        logic [LAYOUT_BITS-1:0]    sh;
        logic [DIM_FIELD_BITS-1:0] raw;
        sh  = layout >> (side * DIM_FIELD_BITS);
        raw = sh[DIM_FIELD_BITS-1:0];
        return (int'(raw) > MAX_DIMS) ? COUNT_BITS'(MAX_DIMS) : COUNT_BITS'(raw);
    endfunction

    // link from destination dimension k to source dimension n
    function automatic logic link_bit(input logic [LAYOUT_BITS-1:0] layout,
                                      input int k, input int n);
        int                     b;
        logic [LAYOUT_BITS-1:0] sh;
        b  = LINK_LSB + k * MAX_DIMS + n;
        sh = layout >> b;
        return (b < LAYOUT_BITS) ? sh[0] : 1'b0;
    endfunction

endpackage

@@ sv/multidim_block_copy_address_generator.sv @@
// top level of the multidimensional block copy address generator
// uses mbcag_pkg, mbcag_dim_cell, mbcag_stride_gen and assert_macros.svh
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+------------------------------------
//  request  | i_valid     | o_ready     | i_restart
//  result   | o_valid     | i_ready     | o_src_addr, o_dst_addr, o_last
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// one request beat per cycle while o_ready is high; each result passes the stage 1, 2 and 3 registers before o_valid
// the counter step for the next beat is one pass through the chain of dimension cells
// after reset and after each register write the strides are recomputed,
// one multiply per cycle, and o_ready stays low meanwhile
// a stalled result holds the three-stage pipe; apart from stride updates, o_ready drops only once all stages are full
`include "assert_macros.svh"

module multidim_block_copy_address_generator import mbcag_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_restart,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OUT_ADDR_BITS-1:0] o_src_addr,
    output logic [OUT_ADDR_BITS-1:0] o_dst_addr,
    output logic                     o_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [REG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_BITS-1:0]      i_cfg_data
);

    // configuration registers
    logic [CFG_BITS-1:0]    r_src_ext, r_src_start, r_src_end;
    logic [CFG_BITS-1:0]    r_dst_ext, r_dst_start, r_dst_end;
    logic [LAYOUT_BITS-1:0] r_layout;

    logic w_cfg_wr, w_cfg_start, w_in_accept, w_busy, w_src_busy, w_dst_busy;

    logic [COUNT_BITS-1:0] w_ns, w_nt;
    t_index_vec            w_src_init, w_src_end, w_dst_init, w_dst_end;
    t_stride_vec           w_src_stride, w_dst_stride;
    logic [MAX_DIMS-1:0]   w_dst_active;
    logic [MAX_DIMS-1:0]   w_link [MAX_DIMS];

    t_index_vec            r_src_idx;
    t_index_vec            w_src_cur;
    t_index_vec            w_src_chain [MAX_DIMS+1];
    logic                  w_carry [MAX_DIMS+1];
    t_index_vec            w_dst_cur;
    t_cell_ctrl            w_cell_ctrl;
    logic                  w_last;
    t_index_vec            w_src_use, w_dst_use;

    // pipeline registers
    logic                  r_s1_valid, r_s2_valid, r_s3_valid;
    t_index_vec            r_s1_src, r_s1_dst;
    logic                  r_s1_last, r_s2_last, r_s3_last;
    t_stride_vec           r_s2_src_prod, r_s2_dst_prod;
    logic [ADDR_BITS-1:0]  r_s3_src_sum, r_s3_dst_sum;
    logic [ADDR_BITS-1:0]  n_src_sum, n_dst_sum;
    logic                  w_en1, w_en2, w_en3;

    // register writes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_cfg_start = w_cfg_wr && (i_cfg_index < REG_IDX_BITS'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ext   <= CFG_RESET;
            r_src_start <= CFG_RESET;
            r_src_end   <= CFG_RESET;
            r_dst_ext   <= CFG_RESET;
            r_dst_start <= CFG_RESET;
            r_dst_end   <= CFG_RESET;
            r_layout    <= LAYOUT_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SRC_EXTENTS: r_src_ext   <= i_cfg_data;
                REG_SRC_STARTS:  r_src_start <= i_cfg_data;
                REG_SRC_ENDS:    r_src_end   <= i_cfg_data;
                REG_DST_EXTENTS: r_dst_ext   <= i_cfg_data;
                REG_DST_STARTS:  r_dst_start <= i_cfg_data;
                REG_DST_ENDS:    r_dst_end   <= i_cfg_data;
                REG_LAYOUT:      r_layout    <= i_cfg_data[LAYOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stride sequencers
    mbcag_stride_gen u_src_stride (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg_start),
        .i_extents (r_src_ext),
        .o_stride  (w_src_stride),
        .o_busy    (w_src_busy)
    );

    mbcag_stride_gen u_dst_stride (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg_start),
        .i_extents (r_dst_ext),
        .o_stride  (w_dst_stride),
        .o_busy    (w_dst_busy)
    );

    assign w_busy = w_src_busy || w_dst_busy;

    // clamped windows, counts and links
    always_comb begin
        w_ns = dim_count(r_layout, SIDE_SRC);
        w_nt = dim_count(r_layout, SIDE_DST);
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_src_init[d] = umin(field_of(r_src_start, d), field_of(r_src_ext, d)) - 1'b1;
            w_src_end[d]  = umin(field_of(r_src_end, d), field_of(r_src_ext, d));
            w_dst_init[d] = umin(field_of(r_dst_start, d), field_of(r_dst_ext, d)) - 1'b1;
            w_dst_end[d]  = umin(field_of(r_dst_end, d), field_of(r_dst_ext, d));
            w_dst_active[d] = (COUNT_BITS'(d) < w_nt);
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            for (int n = 0; n < MAX_DIMS; n++) begin
                w_link[k][n] = link_bit(r_layout, k, n) && (COUNT_BITS'(n) < w_ns);
            end
        end
    end

    // request handshake
    assign w_en3       = !r_s3_valid || i_ready;
    assign w_en2       = !r_s2_valid || w_en3;
    assign w_en1       = !r_s1_valid || w_en2;
    assign o_ready     = !w_busy && w_en1;
    assign w_in_accept = i_valid && o_ready;

    // source counters, stepped by the cell chain
    assign w_src_cur      = i_restart ? w_src_init : r_src_idx;
    assign w_src_chain[0] = w_src_cur;
    assign w_carry[0]     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_busy) begin
            r_src_idx <= w_src_init;
        end else if (w_in_accept) begin
            r_src_idx <= w_src_chain[MAX_DIMS];
        end
    end

    // chain of destination dimension cells, dimension 0 fastest
    // each cell narrows active down to its own dimension
    assign w_cell_ctrl.load_init = w_busy;
    assign w_cell_ctrl.step      = w_in_accept;
    assign w_cell_ctrl.restart   = i_restart;
    assign w_cell_ctrl.active    = 1'b1;

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
        t_cell_ctrl w_ctrl;

        always_comb begin
            w_ctrl        = w_cell_ctrl;
            w_ctrl.active = w_dst_active[k];
        end

        mbcag_dim_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_init     (w_dst_init[k]),
            .i_end      (w_dst_end[k]),
            .i_src_init (w_src_init),
            .i_src_end  (w_src_end),
            .i_link     (w_link[k]),
            .i_carry    (w_carry[k]),
            .i_src      (w_src_chain[k]),
            .o_src      (w_src_chain[k+1]),
            .o_carry    (w_carry[k+1]),
            .o_cur      (w_dst_cur[k])
        );
    end

    // last beat when the outermost active dimension wraps, or every beat when no dimension is active
    always_comb begin
        w_last = (w_nt == '0);
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (w_carry[k+1] && (COUNT_BITS'(k + 1) == w_nt)) begin
                w_last = 1'b1;
            end
        end
    end

    // indices of dimensions beyond the counts do not count
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_src_use[d] = (COUNT_BITS'(d) < w_ns) ? w_src_cur[d] : '0;
            w_dst_use[d] = w_dst_active[d] ? w_dst_cur[d] : '0;
        end
    end

    // adder stage sums
    always_comb begin
        n_src_sum = '0;
        n_dst_sum = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            n_src_sum = n_src_sum + r_s2_src_prod[d];
            n_dst_sum = n_dst_sum + r_s2_dst_prod[d];
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_en1) r_s1_valid <= w_in_accept;
            if (w_en2) r_s2_valid <= r_s1_valid;
            if (w_en3) r_s3_valid <= r_s2_valid;
        end
    end

    // pipeline payload: indices, products, sums
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_src  <= w_src_use;
            r_s1_dst  <= w_dst_use;
            r_s1_last <= w_last;
        end
        if (w_en2) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_s2_src_prod[d] <= ADDR_BITS'(r_s1_src[d] * w_src_stride[d]);
                r_s2_dst_prod[d] <= ADDR_BITS'(r_s1_dst[d] * w_dst_stride[d]);
            end
            r_s2_last <= r_s1_last;
        end
        if (w_en3) begin
            r_s3_src_sum <= n_src_sum;
            r_s3_dst_sum <= n_dst_sum;
            r_s3_last    <= r_s2_last;
        end
    end

    assign o_valid    = r_s3_valid;
    assign o_src_addr = OUT_ADDR_BITS'(r_s3_src_sum);
    assign o_dst_addr = OUT_ADDR_BITS'(r_s3_dst_sum);
    assign o_last     = r_s3_last;

    // checks
    `CHK_ALWAYS(a_rst_blocks_req, i_clk, !i_rst_n |=> !o_ready, "request taken right after reset")
    `CHK_ON(a_cfg_blocks_req, i_clk, i_rst_n, w_cfg_start |=> !o_ready, "request taken during stride update")
    `CHK_ON(a_accept_fills, i_clk, i_rst_n, w_in_accept |=> r_s1_valid, "accepted beat lost in first stage")

endmodule

@@ sv/mbcag_dim_cell.sv @@
// one destination dimension cell of the odometer chain
// holds one destination counter, steps the linked source counters; uses mbcag_pkg
module mbcag_dim_cell import mbcag_pkg::*; (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [INDEX_BITS-1:0] i_init,
    input  logic [INDEX_BITS-1:0] i_end,
    input  t_index_vec            i_src_init,
    input  t_index_vec            i_src_end,
    input  logic [MAX_DIMS-1:0]   i_link,
    input  logic                  i_carry,
    input  t_index_vec            i_src,
    output t_index_vec            o_src,
    output logic                  o_carry,
    output logic [INDEX_BITS-1:0] o_cur
);

    logic [INDEX_BITS-1:0] r_idx;
    logic [INDEX_BITS-1:0] n_idx;
    logic [INDEX_BITS-1:0] w_inc;
    logic                  w_step;
    logic                  w_wrap;

    // position seen by this beat, back at the corner on restart
    assign o_cur  = i_ctrl.restart ? i_init : r_idx;
    assign w_step = i_carry && i_ctrl.active;
    assign w_inc  = o_cur + 1'b1;
    assign w_wrap = (w_inc >= i_end);

    // own counter step, carry goes to the next dimension
    always_comb begin
        n_idx   = o_cur;
        o_carry = 1'b0;
        if (w_step) begin
            n_idx   = w_wrap ? i_init : w_inc;
            o_carry = w_wrap;
        end
    end

    // linked source counters step once and wrap inside their window
    always_comb begin
        logic [INDEX_BITS-1:0] s;
        o_src = i_src;
        for (int n = 0; n < MAX_DIMS; n++) begin
            s = i_src[n] + 1'b1;
            if (w_step && i_link[n]) begin
                o_src[n] = (s >= i_src_end[n]) ? i_src_init[n] : s;
            end
        end
    end

    // counter register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_init) begin
            r_idx <= i_init;
        end else if (i_ctrl.step) begin
            r_idx <= n_idx;
        end
    end

endmodule

@@ sv/mbcag_stride_gen.sv @@
// stride sequencer: prefix products of the extents, one multiply per cycle
// uses mbcag_pkg
module mbcag_stride_gen import mbcag_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CFG_BITS-1:0] i_extents,
    output t_stride_vec         o_stride,
    output logic                o_busy
);

    logic                            r_busy;
    logic [STEP_BITS-1:0]            r_step;
    logic [ADDR_BITS-1:0]            r_acc;
    t_stride_vec                     r_stride;
    logic [INDEX_BITS-1:0]           w_ext;
    logic [ADDR_BITS+INDEX_BITS-1:0] w_prod;

    // extent of the dimension being folded in
    always_comb begin
        w_ext = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (int'(r_step) == d) begin
                w_ext = field_of(i_extents, d);
            end
        end
    end

    assign w_prod = r_acc * w_ext;

    // sequencer: restart on reset or register write, then one stride per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy      <= 1'b1;
            r_step      <= '0;
            r_acc       <= ADDR_BITS'(1);
            r_stride[0] <= ADDR_BITS'(1);
        end else if (r_busy) begin
            r_acc <= w_prod[ADDR_BITS-1:0];
            for (int d = 1; d < MAX_DIMS; d++) begin
                if (int'(r_step) == d - 1) begin
                    r_stride[d] <= w_prod[ADDR_BITS-1:0];
                end
            end
            if (int'(r_step) == STRIDE_STEPS - 1) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_stride = r_stride;
    assign o_busy   = r_busy;

endmodule
